// ===== rtl/lsc_pkg.sv =====
// Package for the LRU slot cache policy block.
// Holds default sizes, fixed field widths, controller states and the
// command/status structs shared by the controller and the datapath.
package lsc_pkg;

  // Default sizes, handed down from the top level parameters
  localparam int SLOT_COUNT_DEF = 8;
  localparam int TAG_BITS_DEF   = 16;
  localparam int STAMP_BITS_DEF = 32;

  // Fixed widths of the transaction fields
  localparam int FILE_NUM_W = 16;
  localparam int SLOT_OUT_W = 3;
  localparam int EV_TAG_W   = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } lsc_state_t;

  // Controller to datapath
  typedef struct packed {
    logic start;       // latch request, clear trackers
    logic rd_en;       // read slot memories at the scan address
    logic eval_en;     // evaluate the slot read in the previous cycle
    logic eval_first;  // evaluated slot is slot zero
    logic commit;      // update directory and load the result register
  } lsc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic eval_hit;    // evaluated slot is a valid tag match
    logic out_free;    // result register can take a new transaction
  } lsc_status_t;

endpackage : lsc_pkg

// ===== rtl/lsc_if.sv =====
// Channel interfaces of the LRU slot cache policy block.
// Depends on lsc_pkg for the fixed field widths.
interface lsc_in_if
  import lsc_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [FILE_NUM_W-1:0] file_number;
  logic                  fill_ok;

  modport source (output valid, output file_number, output fill_ok, input ready);
  modport sink   (input valid, input file_number, input fill_ok, output ready);
endinterface : lsc_in_if

interface lsc_out_if
  import lsc_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [SLOT_OUT_W-1:0] slot;
  logic                  granted;
  logic                  evicted;
  logic [EV_TAG_W-1:0]   evicted_tag;

  modport source (output valid, output hit, output slot, output granted,
                  output evicted, output evicted_tag, input ready);
  modport sink   (input valid, input hit, input slot, input granted,
                  input evicted, input evicted_tag, output ready);
endinterface : lsc_out_if

// ===== rtl/lsc_ctrl.sv =====
// Controller of the LRU slot cache policy block: sequences one request
// through scan, evaluation and commit. Depends on lsc_pkg.
module lsc_ctrl
  import lsc_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  localparam int SLOT_W = $clog2(SLOT_COUNT),
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lsc_status_t       status,
  output lsc_cmd_t          cmd,
  output logic [SLOT_W-1:0] rd_addr
);

  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(SLOT_COUNT);

  lsc_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign rd_addr = idx_r[SLOT_W-1:0];

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          idx_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_en      = (idx_r != LAST_IDX);
        cmd.eval_en    = (idx_r != '0);
        cmd.eval_first = (idx_r == CNT_W'(1));
        idx_nxt        = idx_r + CNT_W'(1);
        // stop at the first valid match, else after the last slot
        if ((cmd.eval_en && status.eval_hit) || idx_r == LAST_IDX) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule : lsc_ctrl

// ===== rtl/lsc_dpath.sv =====
// Datapath of the LRU slot cache policy block: slot memories, valid bits,
// use counter, scan trackers and result register. Depends on lsc_pkg.
module lsc_dpath
  import lsc_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int TAG_BITS   = TAG_BITS_DEF,
  parameter int STAMP_BITS = STAMP_BITS_DEF,
  localparam int SLOT_W = $clog2(SLOT_COUNT)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lsc_cmd_t              cmd,
  input  logic [SLOT_W-1:0]     rd_addr,
  output lsc_status_t           status,
  input  logic [FILE_NUM_W-1:0] in_file_number,
  input  logic                  in_fill_ok,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_hit,
  output logic [SLOT_OUT_W-1:0] out_slot,
  output logic                  out_granted,
  output logic                  out_evicted,
  output logic [EV_TAG_W-1:0]   out_evicted_tag
);

  logic [TAG_BITS-1:0]   tag_mem   [SLOT_COUNT];
  logic [STAMP_BITS-1:0] stamp_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid_r;
  logic [STAMP_BITS-1:0] use_cnt_r;

  logic [TAG_BITS-1:0]   req_tag_r;
  logic                  fill_r;
  logic [TAG_BITS-1:0]   rd_tag_r;
  logic [STAMP_BITS-1:0] rd_stamp_r;
  logic [SLOT_W-1:0]     rd_slot_r;

  logic                  hit_r;
  logic [SLOT_W-1:0]     hit_slot_r;
  logic                  have_empty_r;
  logic [SLOT_W-1:0]     empty_at_r;
  logic [STAMP_BITS-1:0] best_r;
  logic [SLOT_W-1:0]     best_slot_r;
  logic [TAG_BITS-1:0]   best_tag_r;

  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [SLOT_OUT_W-1:0] out_slot_r;
  logic                  out_granted_r;
  logic                  out_evicted_r;
  logic [EV_TAG_W-1:0]   out_evicted_tag_r;

  logic [FILE_NUM_W+TAG_BITS-1:0] fn_ext;
  logic [TAG_BITS+EV_TAG_W-1:0]   etag_ext;
  logic [SLOT_W+SLOT_OUT_W-1:0]   slot_ext;
  logic [STAMP_BITS-1:0]          stamp_nxt;
  logic [SLOT_W-1:0]              victim;
  logic [SLOT_W-1:0]              wr_slot;
  logic                           stamp_we;
  logic                           tag_we;

  // compare on the low tag bits; zero-extend a narrow file number
  assign fn_ext    = {{TAG_BITS{1'b0}}, in_file_number};
  assign etag_ext  = {{EV_TAG_W{1'b0}}, best_tag_r};
  assign victim    = have_empty_r ? empty_at_r : best_slot_r;
  assign wr_slot   = hit_r ? hit_slot_r : victim;
  assign slot_ext  = {{SLOT_OUT_W{1'b0}}, wr_slot};
  assign stamp_nxt = use_cnt_r + STAMP_BITS'(1);
  assign stamp_we  = cmd.commit && (hit_r || fill_r);
  assign tag_we    = cmd.commit && !hit_r && fill_r;

  assign status.eval_hit = valid_r[rd_slot_r] && (rd_tag_r == req_tag_r);
  assign status.out_free = !out_valid_r || out_ready;

  // slot memories: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[wr_slot] <= req_tag_r;
    end
    if (stamp_we) begin
      stamp_mem[wr_slot] <= stamp_nxt;
    end
    if (cmd.rd_en) begin
      rd_tag_r   <= tag_mem[rd_addr];
      rd_stamp_r <= stamp_mem[rd_addr];
      rd_slot_r  <= rd_addr;
    end
  end

  // request and scan trackers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_tag_r    <= fn_ext[TAG_BITS-1:0];
      fill_r       <= in_fill_ok;
      hit_r        <= 1'b0;
      have_empty_r <= 1'b0;
    end else if (cmd.eval_en) begin
      if (status.eval_hit && !hit_r) begin
        hit_r      <= 1'b1;
        hit_slot_r <= rd_slot_r;
      end
      if (!valid_r[rd_slot_r]) begin
        have_empty_r <= 1'b1;
        empty_at_r   <= rd_slot_r;
      end
      if (cmd.eval_first || rd_stamp_r < best_r) begin
        best_r      <= rd_stamp_r;
        best_slot_r <= rd_slot_r;
        best_tag_r  <= rd_tag_r;
      end
    end
  end

  // valid bits and use counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      use_cnt_r <= '0;
    end else if (cmd.commit) begin
      if (hit_r || fill_r) begin
        use_cnt_r <= stamp_nxt;
      end
      if (!hit_r) begin
        valid_r[victim] <= fill_r;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit_r         <= hit_r;
      out_slot_r        <= slot_ext[SLOT_OUT_W-1:0];
      out_granted_r     <= hit_r || fill_r;
      out_evicted_r     <= !hit_r && !have_empty_r;
      out_evicted_tag_r <= (!hit_r && !have_empty_r) ? etag_ext[EV_TAG_W-1:0] : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_slot        = out_slot_r;
  assign out_granted     = out_granted_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_tag = out_evicted_tag_r;

endmodule : lsc_dpath

// ===== rtl/lru_slot_cache_policy_top.sv =====
// Top level of the LRU slot cache policy block: fully associative
// directory with stamp-based LRU replacement. Depends on lsc_pkg, lsc_if,
// lsc_ctrl and lsc_dpath.
//
//   channel   direction  handshake      payload
//   in_chan   sink       valid/ready    file_number[15:0], fill_ok
//   out_chan  source     valid/ready    hit, slot[2:0], granted, evicted,
//                                       evicted_tag[15:0]
//
// Sequencing: one transaction at a time. The time from acceptance to the
// next acceptance is set by the slot scan, one slot per cycle through the
// registered read port of the tag and stamp memories; a hit ends the scan
// at its slot, a miss scans every slot.
// Reset: synchronous, active low; clears valid bits, use counter and
// control. Tag and stamp memories need no clearing pass.
// Stalls: the result register lets the next request in while a result
// waits; a commit holds until the result register is free.
module lru_slot_cache_policy_top
  import lsc_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int TAG_BITS   = TAG_BITS_DEF,
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  lsc_in_if.sink    in_chan,
  lsc_out_if.source out_chan
);

  localparam int SLOT_W = $clog2(SLOT_COUNT);

  lsc_cmd_t          cmd;
  lsc_status_t       status;
  logic [SLOT_W-1:0] rd_addr;

  // sequence scan and commit
  lsc_ctrl #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .status   (status),
    .cmd      (cmd),
    .rd_addr  (rd_addr)
  );

  // hold directory state, compare, track minimum and drive the result
  lsc_dpath #(
    .SLOT_COUNT (SLOT_COUNT),
    .TAG_BITS   (TAG_BITS),
    .STAMP_BITS (STAMP_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .rd_addr         (rd_addr),
    .status          (status),
    .in_file_number  (in_chan.file_number),
    .in_fill_ok      (in_chan.fill_ok),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_hit         (out_chan.hit),
    .out_slot        (out_chan.slot),
    .out_granted     (out_chan.granted),
    .out_evicted     (out_chan.evicted),
    .out_evicted_tag (out_chan.evicted_tag)
  );

endmodule : lru_slot_cache_policy_top

// ===== tb/lsc_lookup_checker.sv =====
`timescale 1ns / 100ps
// Lookup checker for the LRU slot cache policy block: watches both channels,
// predicts each lookup result and compares it with the block's own.
// Depends on lsc_pkg and the channel interfaces in lsc_if.
module lsc_lookup_checker
  import lsc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  lsc_in_if    in_mon,
  lsc_out_if   out_mon,
  output int   fault_total,
  output int   lookups_pending
);

  typedef struct packed {
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  granted;
    logic                  evicted;
    logic [EV_TAG_W-1:0]   evicted_tag;
  } lookup_result_t;

  // Shadow copy of the directory
  logic                      dir_valid [SLOT_COUNT_DEF];
  logic [TAG_BITS_DEF-1:0]   dir_tag   [SLOT_COUNT_DEF];
  logic [STAMP_BITS_DEF-1:0] dir_stamp [SLOT_COUNT_DEF];
  logic [STAMP_BITS_DEF-1:0] use_count;

  lookup_result_t expected_lookups[$];
  int             mismatches;

  function automatic lookup_result_t predict_lookup(input logic [FILE_NUM_W-1:0] fnum,
                                                    input logic fill);
    lookup_result_t            res;
    logic [TAG_BITS_DEF-1:0]   tag;
    logic                      found;
    logic                      have_empty;
    int                        hit_idx;
    int                        empty_idx;
    int                        victim;
    logic [STAMP_BITS_DEF-1:0] oldest;
    tag        = fnum[TAG_BITS_DEF-1:0];
    res        = '0;
    found      = 1'b0;
    have_empty = 1'b0;
    hit_idx    = 0;
    empty_idx  = 0;
    victim     = 0;
    oldest     = '0;
    // lowest-numbered valid match wins
    for (int i = 0; i < SLOT_COUNT_DEF; i++)
      if (!found && dir_valid[i] && dir_tag[i] == tag) begin
        found   = 1'b1;
        hit_idx = i;
      end
    if (found) begin
      use_count          = use_count + 1'b1;
      dir_stamp[hit_idx] = use_count;
      res.hit            = 1'b1;
      res.slot           = hit_idx[SLOT_OUT_W-1:0];
      res.granted        = 1'b1;
      return res;
    end
    // highest empty slot, else lowest slot with the smallest stamp
    for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
      if (!dir_valid[i]) begin
        have_empty = 1'b1;
        empty_idx  = i;
      end
      if (i == 0 || dir_stamp[i] < oldest) begin
        oldest = dir_stamp[i];
        victim = i;
      end
    end
    if (have_empty) begin
      victim = empty_idx;
    end else begin
      res.evicted       = 1'b1;
      res.evicted_tag   = dir_tag[victim][EV_TAG_W-1:0];
      dir_valid[victim] = 1'b0;
    end
    if (fill) begin
      use_count         = use_count + 1'b1;
      dir_valid[victim] = 1'b1;
      dir_tag[victim]   = tag;
      dir_stamp[victim] = use_count;
    end
    res.slot    = victim[SLOT_OUT_W-1:0];
    res.granted = fill;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    lookup_result_t got;
    lookup_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
        dir_valid[i] = 1'b0;
        dir_tag[i]   = '0;
        dir_stamp[i] = '0;
      end
      use_count = '0;
      mismatches = 0;
      expected_lookups.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        expected_lookups.push_back(predict_lookup(in_mon.file_number, in_mon.fill_ok));
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.hit, out_mon.slot, out_mon.granted, out_mon.evicted,
                out_mon.evicted_tag};
        if (expected_lookups.size() == 0) begin
          if (mismatches < 10)
            $display("[%0t] unexpected result: hit=%b slot=%0d granted=%b evicted=%b tag=%h",
                     $realtime, got.hit, got.slot, got.granted, got.evicted,
                     got.evicted_tag);
          mismatches++;
        end else begin
          want = expected_lookups.pop_front();
          if (got.hit !== want.hit || got.slot !== want.slot ||
              got.granted !== want.granted || got.evicted !== want.evicted ||
              got.evicted_tag !== want.evicted_tag) begin
            if (mismatches < 10)
              $display("[%0t] result differs: exp hit=%b slot=%0d granted=%b ev=%b tag=%h, got hit=%b slot=%0d granted=%b ev=%b tag=%h",
                       $realtime, want.hit, want.slot, want.granted, want.evicted,
                       want.evicted_tag, got.hit, got.slot, got.granted, got.evicted,
                       got.evicted_tag);
            mismatches++;
          end
        end
      end
    end
    fault_total     <= mismatches;
    lookups_pending <= expected_lookups.size();
  end

endmodule : lsc_lookup_checker

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the testbench for the LRU slot cache policy block: clock, reset,
// request stimulus, result back-pressure and the verdict.
// Depends on lsc_pkg, lsc_if, the block's RTL and lsc_lookup_checker.
module tb_top
  import lsc_pkg::*;
();

  localparam int RANDOM_LOOKUPS = 1950;
  localparam int HOT_TAGS       = 10;   // a few more tags than slots
  localparam int IDLE_PCT       = 23;
  localparam int CALM_FIRST     = 700;  // lookups sent before the stretch without idling
  localparam int CALM_LAST      = 1000;
  localparam int DRAIN_CYCLES   = 30;

  logic clk;
  logic rst_n;
  logic calm;     // high while neither side idles
  int   fault_total;
  int   lookups_pending;

  lsc_in_if  in_chan ();
  lsc_out_if out_chan ();

  lru_slot_cache_policy_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  lsc_lookup_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_chan),
    .out_mon         (out_chan),
    .fault_total     (fault_total),
    .lookups_pending (lookups_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Back-pressure on the result channel: drop ready at random, except in
  // the calm stretch.
  always @(posedge clk) begin
    if (!rst_n)
      out_chan.ready <= 1'b0;
    else
      out_chan.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Offer one request and hold it until the transaction is taken. Valid is
  // left high at the accepting edge so that a back-to-back request only
  // changes the payload; it is lowered only when a gap is inserted.
  task automatic send_lookup(input logic [FILE_NUM_W-1:0] fnum, input logic fill);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.file_number <= fnum;
    in_chan.fill_ok     <= fill;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  initial begin
    logic [FILE_NUM_W-1:0] hot_tag [HOT_TAGS];
    logic [FILE_NUM_W-1:0] fnum;
    logic                  fill;
    // Drive every request input to a known value before the first edge
    rst_n               = 1'b0;
    calm                = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.file_number = '0;
    in_chan.fill_ok     = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Tag zero on an empty directory must miss even though
    // the tag memory may hold zeros; fill it with extreme tags, highest
    // slot first.
    send_lookup(16'h0000, 1'b0);   // miss into an empty slot, fill fails
    send_lookup(16'h0000, 1'b1);
    send_lookup(16'hFFFF, 1'b1);
    send_lookup(16'h0001, 1'b1);
    send_lookup(16'h8000, 1'b1);
    send_lookup(16'h5555, 1'b1);
    send_lookup(16'hAAAA, 1'b1);
    send_lookup(16'h7FFF, 1'b1);
    send_lookup(16'hFFFE, 1'b1);   // directory now full
    send_lookup(16'h0000, 1'b0);   // hit: fill flag plays no part
    send_lookup(16'hFFFF, 1'b1);   // hit, refresh stamp
    send_lookup(16'h1234, 1'b0);   // evict LRU, failed fill leaves it empty
    send_lookup(16'h1234, 1'b1);   // miss into that empty slot, no eviction
    send_lookup(16'h4321, 1'b1);   // evict LRU on a full directory
    send_lookup(16'h8000, 1'b1);   // re-install an evicted tag
    send_lookup(16'h4321, 1'b0);   // hit
    send_lookup(16'hFFFE, 1'b0);   // hit in slot zero
    send_lookup(16'h0F0F, 1'b0);   // eviction with failed fill
    send_lookup(16'h0F0F, 1'b0);   // failed fill into an empty slot
    send_lookup(16'hF0F0, 1'b1);
    send_lookup(16'h0F0F, 1'b1);

    // Random part: mostly a small hot set so that hits and LRU evictions
    // dominate, with fully random tags mixed in to toggle every bit.
    for (int k = 0; k < HOT_TAGS; k++)
      hot_tag[k] = FILE_NUM_W'($urandom_range(16'hFFFF));
    for (int n = 0; n < RANDOM_LOOKUPS; n++) begin
      calm <= (n >= CALM_FIRST && n < CALM_LAST);
      if ($urandom_range(99) < 3)
        hot_tag[$urandom_range(HOT_TAGS - 1)] = FILE_NUM_W'($urandom_range(16'hFFFF));
      if ($urandom_range(99) < 75)
        fnum = hot_tag[$urandom_range(HOT_TAGS - 1)];
      else
        fnum = FILE_NUM_W'($urandom_range(16'hFFFF));
      fill = ($urandom_range(99) < 85);
      send_lookup(fnum, fill);
    end
    in_chan.valid <= 1'b0;
    calm          <= 1'b0;

    // Drain: wait for every predicted result, then let the block settle
    @(posedge clk);
    while (lookups_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_total == 0 && lookups_pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule : tb_top

// ===== files.f =====
rtl/lsc_pkg.sv
rtl/lsc_if.sv
rtl/lsc_ctrl.sv
rtl/lsc_dpath.sv
rtl/lru_slot_cache_policy_top.sv
tb/lsc_lookup_checker.sv
tb/tb_top.sv
